// ===== hw/rtl/ohd_pkg.sv =====
package ohd_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int COS_STAGES     = 7;

  localparam int DIR_W  = 18;
  localparam int T1_W   = 20;
  localparam int T2_W   = 22;
  localparam int GAIN_W = 17;

  localparam int Z_W   = 29;
  localparam int ACC_W = 31;

  localparam logic [ACC_W-1:0] COEF_C1 = 31'd331168970;
  localparam logic [ACC_W-1:0] COEF_C2 = 31'd1089502240;
  localparam logic [ACC_W-1:0] COEF_C3 = 31'd1433727481;
  localparam logic [ACC_W-1:0] COEF_C4 = 31'd1010737360;
  localparam logic [24:0]      ONE_Q24 = 25'd16777216;

endpackage

// ===== hw/rtl/oscillating_hill_displacement.sv =====
// channel    | dir | fields
// s_axis     | in  | tdata: sim_time, point_x, point_y, point_z (32 bits each)
// m_axis     | out | tdata: moved_x, moved_y, moved_z (32 bits each)
// apb        | in  | amplitude, frequency, origin_x/y/z, dir_x/y/z at 4*i
//
// one item per cycle while the output is not stalled
// pipeline depth is set by the three cosine pipelines (7 stages) and the product chain
// a stage advances whenever it or any stage after it is empty, so bubbles close up
// rst_ni clears valid bits and resets config and tangent registers; the first tangent
// is registered from the direction, the second from the direction and the first
module oscillating_hill_displacement #(
  parameter int CosTableBits = ohd_pkg::COS_TABLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // sim_time, point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // moved_x, moved_y, moved_z
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ohd_pkg::*;

  typedef enum logic [2:0] {
    REG_AMPLITUDE = 3'd0,
    REG_FREQUENCY = 3'd1,
    REG_ORIGIN_X  = 3'd2,
    REG_ORIGIN_Y  = 3'd3,
    REG_ORIGIN_Z  = 3'd4,
    REG_DIR_X     = 3'd5,
    REG_DIR_Y     = 3'd6,
    REG_DIR_Z     = 3'd7
  } reg_idx_e;

  localparam int StIn    = 0;
  localparam int StRel   = 1;
  localparam int StProd  = 2;
  localparam int StPhase = 3;
  localparam int StCos   = 4;
  localparam int StHill  = StCos + COS_STAGES;
  localparam int StBump1 = StHill + 1;
  localparam int StBump2 = StBump1 + 1;
  localparam int StDisp  = StBump2 + 1;
  localparam int StOut   = StDisp + 1;
  localparam int NumSt   = StOut + 1;

  // configuration
  logic [31:0]                  amp_q, freq_q;
  logic [2:0][31:0]             org_q;
  logic [2:0][DIR_W-1:0]        dir_q;
  logic [2:0][T1_W-1:0]         t1_d, t1_q;
  logic [2:0][T2_W-1:0]         t2_d, t2_q;
  logic signed [35:0]           t1_full [3];
  logic signed [37:0]           t2_full [3];
  logic                         cfg_we;
  reg_idx_e                     cfg_idx;

  // pipeline control
  logic [NumSt-1:0]             vld_q, en;
  logic                         in_acc, out_acc;

  // payload
  logic [2:0][31:0]             pt_q [StDisp+1];
  logic [31:0]                  hill_ph_d;
  logic [31:0]                  hill_ph_q [StPhase+1];
  logic [2:0][31:0]             rel_q;
  logic [2:0][31:0]             px_d, py_d, px_q, py_q;
  logic [31:0]                  sum_x, sum_y;
  logic [31:0]                  phx_q, phy_q;
  logic [GAIN_W-1:0]            gain_h, gain_x, gain_y;
  logic [GAIN_W-1:0]            b1_q, b2_q, b2_dly_q;
  logic signed [48:0]           hill_mul, s1_mul, s_mul;
  logic [31:0]                  h_q, s1_q, s_q;
  logic signed [49:0]           dsp_mul [3];
  logic [2:0][33:0]             dsp_q;
  logic signed [34:0]           moved_sum [3];
  logic [2:0][31:0]             moved_d, moved_q;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= '0;
      freq_q <= '0;
      org_q  <= '0;
      dir_q  <= {18'sd65536, 18'sd0, 18'sd0};
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AMPLITUDE: amp_q    <= pwdata;
        REG_FREQUENCY: freq_q   <= pwdata;
        REG_ORIGIN_X:  org_q[0] <= pwdata;
        REG_ORIGIN_Y:  org_q[1] <= pwdata;
        REG_ORIGIN_Z:  org_q[2] <= pwdata;
        REG_DIR_X:     dir_q[0] <= pwdata[DIR_W-1:0];
        REG_DIR_Y:     dir_q[1] <= pwdata[DIR_W-1:0];
        REG_DIR_Z:     dir_q[2] <= pwdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_AMPLITUDE: prdata = amp_q;
      REG_FREQUENCY: prdata = freq_q;
      REG_ORIGIN_X:  prdata = org_q[0];
      REG_ORIGIN_Y:  prdata = org_q[1];
      REG_ORIGIN_Z:  prdata = org_q[2];
      REG_DIR_X:     prdata = 32'(dir_q[0]);
      REG_DIR_Y:     prdata = 32'(dir_q[1]);
      REG_DIR_Z:     prdata = 32'(dir_q[2]);
      default:       prdata = '0;
    endcase
  end

  // tangents, first from the direction, second from the direction and the first
  always_comb begin
    t1_full[0] = $signed(dir_q[2]) * $signed(dir_q[2]) - $signed(dir_q[0]) * $signed(dir_q[1]);
    t1_full[1] = $signed(dir_q[0]) * $signed(dir_q[0]) - $signed(dir_q[1]) * $signed(dir_q[2]);
    t1_full[2] = $signed(dir_q[1]) * $signed(dir_q[1]) - $signed(dir_q[2]) * $signed(dir_q[0]);
    t2_full[0] = $signed(dir_q[1]) * $signed(t1_q[2]) - $signed(dir_q[2]) * $signed(t1_q[1]);
    t2_full[1] = $signed(dir_q[2]) * $signed(t1_q[0]) - $signed(dir_q[0]) * $signed(t1_q[2]);
    t2_full[2] = $signed(dir_q[0]) * $signed(t1_q[1]) - $signed(dir_q[1]) * $signed(t1_q[0]);
    for (int i = 0; i < 3; i++) begin
      t1_d[i] = t1_full[i][35:16];
      t2_d[i] = t2_full[i][37:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= {20'sd0, 20'sd0, 20'sd65536};
      t2_q <= {22'sd0, 22'sd65536, 22'sd0};
    end else begin
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
  end

  // stage k moves when some stage from k on is empty or the output is taken
  always_comb begin
    for (int k = 0; k < NumSt; k++) begin
      en[k] = m_axis_tready || ((vld_q | NumSt'((64'd1 << k) - 64'd1)) != '1);
    end
  end

  assign s_axis_tready = en[StIn];
  assign m_axis_tvalid = vld_q[StOut];
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[StIn]) vld_q[StIn] <= s_axis_tvalid;
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign hill_ph_d = freq_q * s_axis_tdata[31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px_d[i] = $signed(rel_q[i]) * $signed(t1_q[i]);
      py_d[i] = $signed(rel_q[i]) * $signed(t2_q[i]);
    end
    sum_x = px_q[0] + px_q[1] + px_q[2];
    sum_y = py_q[0] + py_q[1] + py_q[2];
  end

  ohd_cos #(.CosTableBits(CosTableBits)) u_cos_hill (
    .clk_i  (clk_i),
    .en_i   (en[StCos +: COS_STAGES]),
    .phase_i(hill_ph_q[StPhase]),
    .gain_o (gain_h)
  );

  ohd_cos #(.CosTableBits(CosTableBits)) u_cos_x (
    .clk_i  (clk_i),
    .en_i   (en[StCos +: COS_STAGES]),
    .phase_i(phx_q),
    .gain_o (gain_x)
  );

  ohd_cos #(.CosTableBits(CosTableBits)) u_cos_y (
    .clk_i  (clk_i),
    .en_i   (en[StCos +: COS_STAGES]),
    .phase_i(phy_q),
    .gain_o (gain_y)
  );

  assign hill_mul = $signed(amp_q) * $signed({1'b0, gain_h});
  assign s1_mul   = $signed(h_q) * $signed({1'b0, b1_q});
  assign s_mul    = $signed(s1_q) * $signed({1'b0, b2_dly_q});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsp_mul[i]   = $signed(s_q) * $signed(dir_q[i]);
      moved_sum[i] = $signed({{3{pt_q[StDisp][i][31]}}, pt_q[StDisp][i]})
                     + $signed({dsp_q[i][33], dsp_q[i]});
      if (!moved_sum[i][34] && (moved_sum[i][33:31] != 3'b000)) begin
        moved_d[i] = 32'h7fff_ffff;
      end else if (moved_sum[i][34] && (moved_sum[i][33:31] != 3'b111)) begin
        moved_d[i] = 32'h8000_0000;
      end else begin
        moved_d[i] = moved_sum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StIn]) begin
      pt_q[StIn]      <= s_axis_tdata[127:32];
      hill_ph_q[StIn] <= hill_ph_d;
    end
    for (int k = 1; k <= StDisp; k++) begin
      if (en[k]) pt_q[k] <= pt_q[k-1];
    end
    for (int k = 1; k <= StPhase; k++) begin
      if (en[k]) hill_ph_q[k] <= hill_ph_q[k-1];
    end
    if (en[StRel]) begin
      for (int i = 0; i < 3; i++) rel_q[i] <= pt_q[StIn][i] - org_q[i];
    end
    if (en[StProd]) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (en[StPhase]) begin
      // bump phase is the low 16 bits of x - 1/2, as turns
      phx_q <= {sum_x[31:16] ^ 16'h8000, 16'h0000};
      phy_q <= {sum_y[31:16] ^ 16'h8000, 16'h0000};
    end
    if (en[StHill]) begin
      h_q  <= hill_mul[47:16];
      b1_q <= gain_x;
      b2_q <= gain_y;
    end
    if (en[StBump1]) begin
      s1_q     <= s1_mul[47:16];
      b2_dly_q <= b2_q;
    end
    if (en[StBump2]) begin
      s_q <= s_mul[47:16];
    end
    if (en[StDisp]) begin
      for (int i = 0; i < 3; i++) dsp_q[i] <= dsp_mul[i][49:16];
    end
    if (en[StOut]) begin
      moved_q <= moved_d;
    end
  end

  assign m_axis_tdata = {moved_q[2], moved_q[1], moved_q[0]};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[StOut] |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("full pipeline accepted an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(vld_q) ==
      $countones($past(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("item lost or duplicated in pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $stable(dir_q) |-> t1_q == t1_d)
    else $error("first tangent out of date");

endmodule

// ===== hw/rtl/ohd_cos.sv =====
module ohd_cos #(
  parameter int CosTableBits = ohd_pkg::COS_TABLE_BITS
) (
  input  logic                            clk_i,
  input  logic [ohd_pkg::COS_STAGES-1:0]  en_i,
  input  logic [31:0]                     phase_i,
  output logic [ohd_pkg::GAIN_W-1:0]      gain_o
);
  import ohd_pkg::*;

  localparam int Drop   = 32 - CosTableBits;
  localparam int ProdW  = Z_W + ACC_W - 32;
  localparam int MulW   = Z_W + ACC_W;
  localparam logic [17:0] OneQ16 = 18'd65536;

  // fold onto a quarter turn
  logic [32:0]         trunc_d;
  logic [32:0]         half_d;
  logic [32:0]         quarter_full;
  logic [30:0]         quarter_d;
  logic                neg_d;
  logic [30:0]         quarter_q;
  logic                neg_q [0:5];
  logic [61:0]         square;
  logic [Z_W-1:0]      z_q [1:4];
  logic [MulW-1:0]     mul2, mul3, mul4, mul5;
  logic [ACC_W-1:0]    acc3, acc4, acc5;
  logic [ProdW-1:0]    prod_q [2:5];
  logic signed [29:0]  r_full;
  logic [24:0]         r_clamp;
  logic [16:0]         r_q16;
  logic [17:0]         raised;
  logic [GAIN_W-1:0]   gain_d;
  logic [GAIN_W-1:0]   gain_q;

  always_comb begin
    trunc_d = {1'b0, phase_i[31:Drop], {Drop{1'b0}}};
    half_d  = trunc_d[31] ? (33'h1_0000_0000 - trunc_d) : trunc_d;
    if (half_d > 33'h0_4000_0000) begin
      quarter_full = 33'h0_8000_0000 - half_d;
      neg_d        = 1'b1;
    end else begin
      quarter_full = half_d;
      neg_d        = 1'b0;
    end
    quarter_d = quarter_full[30:0];
  end

  assign square = 62'(quarter_q) * 62'(quarter_q);
  assign mul2   = MulW'(z_q[1]) * MulW'(COEF_C4);
  assign acc3   = COEF_C3 - ACC_W'(prod_q[2]);
  assign mul3   = MulW'(z_q[2]) * MulW'(acc3);
  assign acc4   = COEF_C2 - ACC_W'(prod_q[3]);
  assign mul4   = MulW'(z_q[3]) * MulW'(acc4);
  assign acc5   = COEF_C1 - ACC_W'(prod_q[4]);
  assign mul5   = MulW'(z_q[4]) * MulW'(acc5);

  always_comb begin
    r_full = $signed({5'b0, ONE_Q24}) - $signed({2'b0, prod_q[5]});
    if (r_full < 0) begin
      r_clamp = '0;
    end else if (r_full > $signed({5'b0, ONE_Q24})) begin
      r_clamp = ONE_Q24;
    end else begin
      r_clamp = r_full[24:0];
    end
    r_q16  = r_clamp[24:8];
    raised = neg_q[5] ? (OneQ16 + {1'b0, r_q16}) : (OneQ16 - {1'b0, r_q16});
    gain_d = raised[17:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quarter_q <= quarter_d;
      neg_q[0]  <= neg_d;
    end
    if (en_i[1]) begin
      z_q[1]   <= square[60:32];
      neg_q[1] <= neg_q[0];
    end
    if (en_i[2]) begin
      z_q[2]    <= z_q[1];
      prod_q[2] <= mul2[MulW-1:32];
      neg_q[2]  <= neg_q[1];
    end
    if (en_i[3]) begin
      z_q[3]    <= z_q[2];
      prod_q[3] <= mul3[MulW-1:32];
      neg_q[3]  <= neg_q[2];
    end
    if (en_i[4]) begin
      z_q[4]    <= z_q[3];
      prod_q[4] <= mul4[MulW-1:32];
      neg_q[4]  <= neg_q[3];
    end
    if (en_i[5]) begin
      prod_q[5] <= mul5[MulW-1:32];
      neg_q[5]  <= neg_q[4];
    end
    if (en_i[6]) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

// ===== tb/oscillating_hill_displacement_tb.sv =====
module oscillating_hill_displacement_tb;

  localparam int COS_BITS = ohd_pkg::COS_TABLE_BITS;

  localparam longint COS_K1  = 331168970;
  localparam longint COS_K2  = 1089502240;
  localparam longint COS_K3  = 1433727481;
  localparam longint COS_K4  = 1010737360;
  localparam longint ONE_Q24 = 16777216;

  typedef enum logic [2:0] {
    REG_AMPLITUDE,
    REG_FREQUENCY,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z
  } hill_reg_e;

  typedef struct packed {
    logic [31:0] point_z;
    logic [31:0] point_y;
    logic [31:0] point_x;
    logic [31:0] sim_time;
  } hill_in_t;

  typedef struct packed {
    logic [31:0] moved_z;
    logic [31:0] moved_y;
    logic [31:0] moved_x;
  } hill_out_t;

  typedef struct packed {
    logic [2:0]  setting;
    logic        typed;
    logic [31:0] sim_time;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
  } probe_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  hill_in_t     s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  logic [31:0]  amp_cfg = '0;
  logic [31:0]  freq_cfg = '0;
  logic [31:0]  origin_cfg [3] = '{32'd0, 32'd0, 32'd0};
  logic [17:0]  dir_cfg [3] = '{18'd0, 18'd0, 18'd65536};
  longint       tan_one [3];
  longint       tan_two [3];

  hill_out_t    moved_q [$];
  int           errors = 0;
  bit           burst = 1'b0;

  // setting 0 keeps the current registers, others are loaded before the row
  probe_row_t probe_rows [20] = '{
    '{3'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{3'd0, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
    '{3'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
    '{3'd0, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF},
    '{3'd0, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000},
    // full hill at the origin, positive overflow
    '{3'd1, 1'b1, 32'h0001_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
      32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_0000},
    // time wraps onto the same half turn
    '{3'd0, 1'b1, 32'h0003_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
      32'h7FFF_FFFF, 32'h7FFF_0000, 32'h7FFF_0000},
    '{3'd0, 1'b1, 32'h0000_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
      32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000},
    '{3'd0, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_4000, 32'h7FFE_C000, 32'h7FFF_0000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h0001_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0, 32'h0, 32'h0},
    // non-unit direction, negative overflow
    '{3'd2, 1'b1, 32'h0001_0000, 32'h8001_0000, 32'h8001_0000, 32'h8001_0000,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
    '{3'd0, 1'b1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
    '{3'd0, 1'b0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h0, 32'h0, 32'h0},
    '{3'd3, 1'b0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h8000_0000, 32'hFFFF_8000, 32'h0000_4000, 32'h7FFF_FFFF,
      32'h0, 32'h0, 32'h0},
    '{3'd4, 1'b0, 32'h0000_4000, 32'h0001_4000, 32'hFFFE_8000, 32'h0000_0000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h0000_C000, 32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h0000_8000, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000,
      32'h0, 32'h0, 32'h0},
    '{3'd0, 1'b0, 32'h0000_2000, 32'h4000_0000, 32'hC000_0000, 32'h2000_0000,
      32'h0, 32'h0, 32'h0}
  };

  oscillating_hill_displacement #(
    .CosTableBits(COS_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cosine of a turn fraction, Q16.16
  function automatic longint cos_of_turn(input logic [31:0] phase);
    longint unsigned t;
    longint unsigned z;
    longint          acc;
    longint          r;
    bit              neg;
    neg = 1'b0;
    t = 64'(phase & ~(32'hFFFF_FFFF >> COS_BITS));
    if (t >= 64'h8000_0000) t = 64'h1_0000_0000 - t;
    if (t > 64'h4000_0000) begin
      t = 64'h8000_0000 - t;
      neg = 1'b1;
    end
    z = (t * t) >> 32;
    acc = COS_K4;
    acc = COS_K3 - longint'((z * acc) >> 32);
    acc = COS_K2 - longint'((z * acc) >> 32);
    acc = COS_K1 - longint'((z * acc) >> 32);
    r = ONE_Q24 - longint'((z * acc) >> 32);
    if (r < 0) r = 0;
    if (r > ONE_Q24) r = ONE_Q24;
    r = r >>> 8;
    return neg ? -r : r;
  endfunction

  function automatic longint bump_gain(input longint q);
    logic [15:0] ph;
    ph = 16'(q - 32768);
    return (65536 - cos_of_turn({ph, 16'h0000})) >>> 1;
  endfunction

  function automatic void update_tangents();
    longint dx, dy, dz, a, b, c;
    dx = $signed(dir_cfg[0]);
    dy = $signed(dir_cfg[1]);
    dz = $signed(dir_cfg[2]);
    a = (dz * dz - dx * dy) >>> 16;
    b = (dx * dx - dy * dz) >>> 16;
    c = (dy * dy - dz * dx) >>> 16;
    tan_one[0] = a;
    tan_one[1] = b;
    tan_one[2] = c;
    tan_two[0] = (dy * c - dz * b) >>> 16;
    tan_two[1] = (dz * a - dx * c) >>> 16;
    tan_two[2] = (dx * b - dy * a) >>> 16;
  endfunction

  function automatic hill_out_t predict_moved(input hill_in_t it);
    logic [31:0] phase;
    longint      h, x_proj, y_proj, s, rel, v;
    longint      pt [3];
    hill_out_t   res;
    phase = freq_cfg * it.sim_time;
    h = (65536 - cos_of_turn(phase)) >>> 1;
    h = (longint'($signed(amp_cfg)) * h) >>> 16;
    pt[0] = $signed(it.point_x);
    pt[1] = $signed(it.point_y);
    pt[2] = $signed(it.point_z);
    x_proj = 0;
    y_proj = 0;
    for (int i = 0; i < 3; i++) begin
      rel = pt[i] - longint'($signed(origin_cfg[i]));
      x_proj += rel * tan_one[i];
      y_proj += rel * tan_two[i];
    end
    x_proj = x_proj >>> 16;
    y_proj = y_proj >>> 16;
    s = (h * bump_gain(x_proj)) >>> 16;
    s = (s * bump_gain(y_proj)) >>> 16;
    for (int i = 0; i < 3; i++) begin
      v = pt[i] + ((s * longint'($signed(dir_cfg[i]))) >>> 16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res[32*i +: 32] = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_dir();
    int v;
    case ($urandom_range(0, 5))
      0: v = 65536;
      1: v = -65536;
      2: v = 0;
      default: v = int'($urandom_range(0, 131072)) - 65536;
    endcase
    return 32'(v);
  endfunction

  task automatic write_reg(input hill_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_AMPLITUDE: amp_cfg = value;
      REG_FREQUENCY: freq_cfg = value;
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: origin_cfg[idx - REG_ORIGIN_X] = value;
      default: begin
        dir_cfg[idx - REG_DIR_X] = value[17:0];
        update_tangents();
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [31:0] amp, input logic [31:0] freq,
                               input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] dx,
                               input logic [31:0] dy, input logic [31:0] dz);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_FREQUENCY, freq);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    // the tangent registers follow a direction write, so let them settle
    repeat (4) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (moved_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_point(input hill_in_t it, input bit typed, input hill_out_t known);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    moved_q.push_back(typed ? known : predict_moved(it));
  endtask

  initial begin
    hill_in_t    it;
    logic [31:0] r;
    logic [31:0] amp, freq;
    update_tangents();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[k]) begin
      if (probe_rows[k].setting != 3'd0) begin
        wait_drained();
        case (probe_rows[k].setting)
          3'd1: write_setting(32'h7FFF_FFFF, 32'h0000_8000, 32'h7FFF_0000, 32'h7FFF_0000,
                              32'h7FFF_0000, 32'h0001_0000, 32'h0, 32'h0);
          3'd2: write_setting(32'h8000_0000, 32'h0001_8000, 32'h8001_0000, 32'h8001_0000,
                              32'h8001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
          3'd3: write_setting(32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                              32'hFFFF_0000, 32'h0, 32'h0);
          default: write_setting(32'h0028_0000, 32'h0001_0000, 32'h0001_0000,
                                 32'hFFFE_0000, 32'h0000_8000, 32'h0,
                                 32'hFFFF_0000, 32'h0001_0000);
        endcase
      end
      send_point({probe_rows[k].pz, probe_rows[k].py, probe_rows[k].px,
                  probe_rows[k].sim_time}, probe_rows[k].typed,
                 {probe_rows[k].mz, probe_rows[k].my, probe_rows[k].mx});
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      r = $urandom();
      amp = ph[0] ? pick_word() : {{11{r[20]}}, r[20:0]};
      freq = $urandom_range(0, 1) ? pick_word() : $urandom_range(0, 32'h0004_0000);
      write_setting(amp, freq, pick_word(), pick_word(), pick_word(),
                    pick_dir(), pick_dir(), pick_dir());
      for (int n = 0; n < 103; n++) begin
        if (n % 26 == 0) burst = ($urandom_range(0, 3) == 0);
        it.sim_time = pick_word();
        for (int i = 0; i < 3; i++) begin
          r = $urandom();
          // each coordinate sits close to the hill centre half the time
          it[32*(i+1) +: 32] = $urandom_range(0, 1) ?
                               origin_cfg[i] + {{14{r[17]}}, r[17:0]} : pick_word();
        end
        send_point(it, 1'b0, '0);
      end
    end
    burst = 1'b0;

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS oscillating_hill_displacement");
    end else begin
      $display("FAIL oscillating_hill_displacement");
    end
    $finish;
  end

  initial begin
    int        stall;
    hill_out_t got;
    hill_out_t want;
    wait (rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      if (moved_q.size() == 0) begin
        if (errors < 40) $display("%0t unexpected item %h", $time, got);
        errors++;
      end else begin
        want = moved_q.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (got[32*f +: 32] !== want[32*f +: 32]) begin
            if (errors < 40) begin
              $display("%0t moved_%s expected %h actual %h", $time,
                       (f == 0) ? "x" : (f == 1) ? "y" : "z",
                       want[32*f +: 32], got[32*f +: 32]);
            end
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL oscillating_hill_displacement");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ohd_pkg.sv
hw/rtl/ohd_cos.sv
hw/rtl/oscillating_hill_displacement.sv
tb/oscillating_hill_displacement_tb.sv
